/* design/tmq_pkg.sv */
package tmq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int COMM_SLOTS  = 16;
    localparam int QD_LOG      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int COMM_W     = 4;
    localparam int SRC_W      = 16;
    localparam int TAG_W      = 15;
    localparam int HANDLE_W   = 16;
    localparam int MASK_W     = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_COMM_MASK = '0;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_FIND  = 1'b1
    } tmq_cmd_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_FULL    = 3'd2,
        ST_FOUND   = 3'd3,
        ST_NONE    = 3'd4
    } tmq_status_t;

    typedef struct packed {
        logic [COMM_W-1:0]   comm;
        logic [SRC_W-1:0]    source;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } tmq_entry_t;

    typedef struct packed {
        logic [COMM_W-1:0] comm;
        logic [SRC_W-1:0]  source;
        logic [TAG_W-1:0]  tag;
        logic              any_source;
        logic              any_tag;
    } tmq_query_t;

    typedef struct packed {
        logic load;
        logic shift;
    } tmq_cell_ctrl_t;

endpackage

/* design/tmq_if.sv */
interface tmq_req_if;
    import tmq_pkg::*;

    logic                valid;
    logic                ready;
    tmq_cmd_t            cmd;
    logic [COMM_W-1:0]   comm_id;
    logic [SRC_W-1:0]    src_rank;
    logic [TAG_W-1:0]    msg_tag;
    logic                any_source;
    logic                any_tag;
    logic [HANDLE_W-1:0] buffer_handle;

    modport source (
        output valid, cmd, comm_id, src_rank, msg_tag, any_source, any_tag, buffer_handle,
        input  ready
    );

    modport sink (
        input  valid, cmd, comm_id, src_rank, msg_tag, any_source, any_tag, buffer_handle,
        output ready
    );
endinterface

interface tmq_rsp_if;
    import tmq_pkg::*;

    logic                valid;
    logic                ready;
    tmq_status_t         status;
    logic [HANDLE_W-1:0] found_handle;
    logic [SRC_W-1:0]    found_source;
    logic [TAG_W-1:0]    found_tag;

    modport source (
        output valid, status, found_handle, found_source, found_tag,
        input  ready
    );

    modport sink (
        input  valid, status, found_handle, found_source, found_tag,
        output ready
    );
endinterface

/* design/tmq_cell.sv */
module tmq_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tmq_pkg::tmq_cell_ctrl_t ctrl,
    input  tmq_pkg::tmq_entry_t     load_entry,
    input  tmq_pkg::tmq_query_t     query,
    input  logic                    next_valid,
    input  tmq_pkg::tmq_entry_t     next_entry,
    output logic                    valid,
    output tmq_pkg::tmq_entry_t     entry,
    output logic                    match
);
    import tmq_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    tmq_entry_t entry_reg;
    tmq_entry_t entry_next;

    // A removal closes the gap, so the cell takes its younger neighbour's word.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        priority if (ctrl.shift)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
        else if (ctrl.load)
        begin
            valid_next = 1'b1;
            entry_next = load_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign match = valid_reg
                && (entry_reg.comm == query.comm)
                && (query.any_source || (entry_reg.source == query.source))
                && (query.any_tag || (entry_reg.tag == query.tag));

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

/* design/tmq_match_sel.sv */
module tmq_match_sel (
    input  logic [tmq_pkg::QUEUE_DEPTH-1:0] match,
    input  tmq_pkg::tmq_entry_t             entries [tmq_pkg::QUEUE_DEPTH],
    output logic [tmq_pkg::QUEUE_DEPTH-1:0] covered,
    output logic                            found,
    output tmq_pkg::tmq_entry_t             sel_entry
);
    import tmq_pkg::*;

    logic [QUEUE_DEPTH-1:0] lvl [QD_LOG+1];
    logic [QUEUE_DEPTH-1:0] first;

    // Parallel prefix OR: covered[i] is set when some cell at or below i matches.
    always_comb
    begin
        lvl[0] = match;
        for (int l = 0; l < QD_LOG; l++)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (i >= (1 << l))
                begin
                    lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
                end
                else
                begin
                    lvl[l+1][i] = lvl[l][i];
                end
            end
        end
    end

    assign covered = lvl[QD_LOG];
    assign first   = match & ~(covered << 1);
    assign found   = covered[QUEUE_DEPTH-1];

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel_entry = sel_entry | (entries[i] & {$bits(tmq_entry_t){first[i]}});
        end
    end

endmodule

/* design/tag_matching_queue.sv */
// A result word is registered in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; all cells compare at once,
// the oldest match is picked by a prefix OR, and the cells from it upward shift down.
// A request is taken while the result register is empty or being emptied.
// Reset empties the queue and clears the communicator mask; there is no clearing pass.
module tag_matching_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tmq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tmq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tmq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    tmq_req_if.sink                          req,
    tmq_rsp_if.source                        rsp
);
    import tmq_pkg::*;

    logic [MASK_W-1:0]      mask_reg;
    logic                   reg_hit;

    logic                   accept;
    logic                   comm_ok;
    logic                   store_go;
    logic                   find_go;
    tmq_entry_t             load_entry;
    tmq_query_t             query;

    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_match;
    tmq_entry_t             cell_entry [QUEUE_DEPTH];
    tmq_cell_ctrl_t         cell_ctrl  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] covered;
    logic                   found;
    tmq_entry_t             sel_entry;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    tmq_status_t            out_status_reg;
    tmq_status_t            out_status_next;
    tmq_entry_t             out_entry_reg;
    tmq_entry_t             out_entry_next;

    // Configuration port
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_COMM_MASK);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(mask_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    // Request decode
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign comm_ok   = (int'(req.comm_id) < COMM_SLOTS) && mask_reg[req.comm_id];
    assign store_go  = accept && (req.cmd == CMD_STORE) && comm_ok
                    && !cell_valid[QUEUE_DEPTH-1];
    assign find_go   = accept && (req.cmd == CMD_FIND);

    assign load_entry.comm   = req.comm_id;
    assign load_entry.source = req.src_rank;
    assign load_entry.tag    = req.msg_tag;
    assign load_entry.handle = req.buffer_handle;

    assign query.comm       = req.comm_id;
    assign query.source     = req.src_rank;
    assign query.tag        = req.msg_tag;
    assign query.any_source = req.any_source;
    assign query.any_tag    = req.any_tag;

    // Row of cells, oldest entry in cell 0; valid entries stay packed at the low end.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic       nb_valid;
        tmq_entry_t nb_entry;

        if (i == 0)
        begin : g_head
            assign cell_ctrl[i].load = store_go && !cell_valid[i];
        end
        else
        begin : g_body
            assign cell_ctrl[i].load = store_go && !cell_valid[i] && cell_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign nb_valid = 1'b0;
            assign nb_entry = cell_entry[i];
        end
        else
        begin : g_link
            assign nb_valid = cell_valid[i+1];
            assign nb_entry = cell_entry[i+1];
        end

        assign cell_ctrl[i].shift = find_go && covered[i];

        tmq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[i]),
            .load_entry (load_entry),
            .query      (query),
            .next_valid (nb_valid),
            .next_entry (nb_entry),
            .valid      (cell_valid[i]),
            .entry      (cell_entry[i]),
            .match      (cell_match[i])
        );
    end

    tmq_match_sel u_match_sel (
        .match     (cell_match),
        .entries   (cell_entry),
        .covered   (covered),
        .found     (found),
        .sel_entry (sel_entry)
    );

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_entry_next = '0;
            unique case (req.cmd)
                CMD_STORE:
                begin
                    priority if (!comm_ok)
                    begin
                        out_status_next = ST_UNKNOWN;
                    end
                    else if (cell_valid[QUEUE_DEPTH-1])
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        out_status_next = ST_STORED;
                    end
                end
                CMD_FIND:
                begin
                    out_status_next = found ? ST_FOUND : ST_NONE;
                    out_entry_next  = sel_entry;
                end
                default:
                begin
                    out_status_next = ST_NONE;
                end
            endcase
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_handle = out_entry_reg.handle;
    assign rsp.found_source = out_entry_reg.source;
    assign rsp.found_tag    = out_entry_reg.tag;

endmodule
